// ===== design/tmss_pkg.sv =====
package tmss_pkg;

  // item and arithmetic widths
  localparam int SAMPLE_W = 12;
  // loop counter wide enough for every trim index and window position
  localparam int CNT_W    = 5;

  // rescale constants: 50..4000 onto 0..4095
  localparam logic [SAMPLE_W-1:0] IN_LOW    = 12'd50;
  localparam logic [SAMPLE_W-1:0] OUT_MAX   = 12'd4095;
  localparam logic [SAMPLE_W-1:0] SCALE_DEN = 12'd3950;

  // rescale as one multiply: ceil(4095 * 2^24 / 3950), exact for every 12-bit offset
  localparam int SCALE_SH = 24;
  localparam int SCALE_MW = 25;
  localparam logic [SCALE_MW-1:0] SCALE_MUL =
    SCALE_MW'(((64'(OUT_MAX) << SCALE_SH) + 64'(SCALE_DEN) - 64'd1) / 64'(SCALE_DEN));

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP     = 4'd0,
    OP_WRITE   = 4'd1,
    OP_LOAD    = 4'd2,
    OP_SORT    = 4'd3,
    OP_ACC_CLR = 4'd4,
    OP_SUM     = 4'd5,
    OP_MEAN    = 4'd6,
    OP_SCALE   = 4'd7,
    OP_EMIT    = 4'd8
  } op_t;

  // loop counter actions
  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_CLR  = 2'd1,
    CNT_INC  = 2'd2
  } cnt_op_t;

  // loop limits
  typedef enum logic [1:0] {
    LIM_SORT = 2'd0,
    LIM_SUM  = 2'd1
  } lim_t;

  // jump conditions
  typedef enum logic [2:0] {
    COND_NEVER     = 3'd0,
    COND_ALWAYS    = 3'd1,
    COND_NO_ACCEPT = 3'd2,
    COND_NOT_LAST  = 3'd3,
    COND_OUT_BUSY  = 3'd4
  } cond_t;

  localparam int PC_W = 4;

  // program addresses
  localparam logic [PC_W-1:0] STEP_WAIT    = 4'd0;
  localparam logic [PC_W-1:0] STEP_LOAD    = 4'd1;
  localparam logic [PC_W-1:0] STEP_SORT    = 4'd2;
  localparam logic [PC_W-1:0] STEP_SUMINIT = 4'd3;
  localparam logic [PC_W-1:0] STEP_SUM     = 4'd4;
  localparam logic [PC_W-1:0] STEP_MEAN    = 4'd5;
  localparam logic [PC_W-1:0] STEP_SCALE   = 4'd6;
  localparam logic [PC_W-1:0] STEP_EMIT    = 4'd7;
  localparam logic [PC_W-1:0] PROG_LAST    = STEP_EMIT;

  typedef struct packed {
    logic            in_ready;
    op_t             op;
    cnt_op_t         cnt_op;
    lim_t            lim;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  // control to the datapath
  typedef struct packed {
    logic in_ready;
    op_t  op;
  } ctrl_t;

  // status back to the sequencer
  typedef struct packed {
    logic accept;
    logic out_busy;
  } stat_t;

  // control store
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      STEP_WAIT: w = '{in_ready: 1'b1, op: OP_WRITE, cnt_op: CNT_CLR, lim: LIM_SORT,
                       cond: COND_NO_ACCEPT, target: STEP_WAIT};
      STEP_LOAD: w = '{in_ready: 1'b0, op: OP_LOAD, cnt_op: CNT_CLR, lim: LIM_SORT,
                       cond: COND_NEVER, target: STEP_WAIT};
      STEP_SORT: w = '{in_ready: 1'b0, op: OP_SORT, cnt_op: CNT_INC, lim: LIM_SORT,
                       cond: COND_NOT_LAST, target: STEP_SORT};
      STEP_SUMINIT: w = '{in_ready: 1'b0, op: OP_ACC_CLR, cnt_op: CNT_CLR, lim: LIM_SUM,
                          cond: COND_NEVER, target: STEP_WAIT};
      STEP_SUM: w = '{in_ready: 1'b0, op: OP_SUM, cnt_op: CNT_INC, lim: LIM_SUM,
                      cond: COND_NOT_LAST, target: STEP_SUM};
      STEP_MEAN: w = '{in_ready: 1'b0, op: OP_MEAN, cnt_op: CNT_CLR, lim: LIM_SORT,
                       cond: COND_NEVER, target: STEP_WAIT};
      STEP_SCALE: w = '{in_ready: 1'b0, op: OP_SCALE, cnt_op: CNT_CLR, lim: LIM_SORT,
                        cond: COND_NEVER, target: STEP_WAIT};
      STEP_EMIT: w = '{in_ready: 1'b0, op: OP_EMIT, cnt_op: CNT_CLR, lim: LIM_SORT,
                       cond: COND_OUT_BUSY, target: STEP_EMIT};
      default: w = '{in_ready: 1'b0, op: OP_NOP, cnt_op: CNT_CLR, lim: LIM_SORT,
                     cond: COND_ALWAYS, target: STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== design/tmss_if.sv =====
// sample channel
interface tmss_in_if;
  logic                          valid;
  logic                          ready;
  logic [tmss_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// result channel
interface tmss_out_if;
  logic                          valid;
  logic                          ready;
  logic [tmss_pkg::SAMPLE_W-1:0] smoothed_value;

  modport source (output valid, output smoothed_value, input ready);
  modport sink   (input valid, input smoothed_value, output ready);
endinterface

// ===== design/tmss_seq.sv =====
module tmss_seq #(
  parameter int CW        = 5,
  parameter int SORT_LAST = 7,
  parameter int SUM_LAST  = 5
) (
  input  logic            clk,
  input  logic            rst_n,
  input  tmss_pkg::stat_t stat,
  output tmss_pkg::ctrl_t ctrl,
  output logic [CW-1:0]   cnt
);
  import tmss_pkg::*;

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  ucode_t          uc;
  logic [CW-1:0]   limit;
  logic            take;

  // control word of the current step
  assign uc = ucode_rom(pc_r);

  // loop limit select
  always_comb begin
    unique case (uc.lim)
      LIM_SORT: limit = CW'(SORT_LAST);
      LIM_SUM:  limit = CW'(SUM_LAST);
      default:  limit = '0;
    endcase
  end

  // jump condition
  always_comb begin
    unique case (uc.cond)
      COND_NEVER:     take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_NO_ACCEPT: take = !stat.accept;
      COND_NOT_LAST:  take = (cnt_r != limit);
      COND_OUT_BUSY:  take = stat.out_busy;
      default:        take = 1'b0;
    endcase
  end

  // step counter and loop counter
  always_comb begin
    if (take) begin
      pc_nxt = uc.target;
    end else if (pc_r == PROG_LAST) begin
      pc_nxt = STEP_WAIT;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
    unique case (uc.cnt_op)
      CNT_HOLD: cnt_nxt = cnt_r;
      CNT_CLR:  cnt_nxt = '0;
      CNT_INC:  cnt_nxt = cnt_r + 1'b1;
      default:  cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= STEP_WAIT;
      cnt_r <= '0;
    end else begin
      pc_r  <= pc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign ctrl = '{in_ready: uc.in_ready, op: uc.op};
  assign cnt  = cnt_r;

endmodule

// ===== design/tmss_datapath.sv =====
module tmss_datapath #(
  parameter int SAMPLES = 8,
  parameter int CW      = 5,
  parameter int LO_IDX  = 2,
  parameter int HI_IDX  = 6,
  parameter int COUNT   = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  tmss_in_if.sink         in_chan,
  tmss_out_if.source      out_chan,
  input  tmss_pkg::ctrl_t ctrl,
  input  logic [CW-1:0]   cnt,
  output tmss_pkg::stat_t stat
);
  import tmss_pkg::*;

  localparam int IW      = $clog2(SAMPLES);
  localparam int SUM_W   = SAMPLE_W + $clog2(SAMPLES);
  // rounded-up reciprocal of the trim count, exact for every sum below 2^SUM_W
  localparam int MEAN_SH = SUM_W + 5;
  localparam int MEAN_MW = MEAN_SH + 1;
  localparam int MEAN_DV = (COUNT > 0) ? COUNT : 1;
  localparam logic [MEAN_MW-1:0] MEAN_MUL =
    MEAN_MW'(((64'd1 << MEAN_SH) + 64'(MEAN_DV) - 64'd1) / 64'(MEAN_DV));
  localparam int MPROD_W = SUM_W + MEAN_MW;
  localparam int SPROD_W = SAMPLE_W + SCALE_MW;

  logic [SAMPLE_W-1:0] window_r [SAMPLES];
  logic [SAMPLE_W-1:0] window_nxt [SAMPLES];
  logic [SAMPLE_W-1:0] sort_r [SAMPLES];
  logic [SAMPLE_W-1:0] sort_nxt [SAMPLES];
  logic [IW-1:0]       slot_r, slot_nxt, slot_inc;
  logic [SUM_W-1:0]    acc_r, acc_nxt;
  logic [SAMPLE_W-1:0] mean_r, mean_nxt;
  logic [SAMPLE_W:0]   scaled_r, scaled_nxt;
  logic [SAMPLE_W-1:0] out_data_r, out_data_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                accept, out_busy;
  logic [SAMPLE_W-1:0] mean_diff;
  logic [MPROD_W-1:0]  mean_prod;
  logic [SPROD_W-1:0]  scale_prod;
  logic                in_range;

  assign accept   = in_chan.valid && ctrl.in_ready;
  assign out_busy = out_valid_r && !out_chan.ready;
  assign stat     = '{accept: accept, out_busy: out_busy};

  // ring index wraps at the window size
  assign slot_inc = (slot_r == IW'(SAMPLES - 1)) ? '0 : slot_r + 1'b1;

  // mean by reciprocal multiply, quotient in the bits above the shift
  assign mean_prod = MPROD_W'(acc_r) * MPROD_W'(MEAN_MUL);

  // rescale product, quotient of (mean-50)*4095/3950 above the shift
  assign mean_diff  = mean_r - IN_LOW;
  assign scale_prod = SPROD_W'(mean_diff) * SPROD_W'(SCALE_MUL);

  assign in_range = (cnt >= CW'(LO_IDX)) && (cnt < CW'(HI_IDX));

  always_comb begin
    window_nxt    = window_r;
    sort_nxt      = sort_r;
    slot_nxt      = slot_r;
    acc_nxt       = acc_r;
    mean_nxt      = mean_r;
    scaled_nxt    = scaled_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    unique case (ctrl.op)
      OP_NOP: begin
      end
      OP_WRITE: begin
        if (accept) begin
          slot_nxt             = slot_inc;
          window_nxt[slot_inc] = in_chan.sample;
        end
      end
      OP_LOAD: begin
        sort_nxt = window_r;
      end
      OP_SORT: begin
        // odd-even transposition pass, parity from the pass count
        for (int i = 0; i < SAMPLES - 1; i++) begin
          if ((1'(i) == cnt[0]) && (sort_r[i] > sort_r[i+1])) begin
            sort_nxt[i]   = sort_r[i+1];
            sort_nxt[i+1] = sort_r[i];
          end
        end
      end
      OP_ACC_CLR: begin
        acc_nxt = '0;
      end
      OP_SUM: begin
        // sorted entries stream past the head of the buffer
        if (in_range) begin
          acc_nxt = acc_r + SUM_W'(sort_r[0]);
        end
        for (int i = 0; i < SAMPLES - 1; i++) begin
          sort_nxt[i] = sort_r[i+1];
        end
      end
      OP_MEAN: begin
        mean_nxt = mean_prod[MEAN_SH +: SAMPLE_W];
      end
      OP_SCALE: begin
        // a mean under the low end ends at zero
        scaled_nxt = (mean_r >= IN_LOW) ? scale_prod[SCALE_SH +: SAMPLE_W+1] : '0;
      end
      OP_EMIT: begin
        if (!out_busy) begin
          out_data_nxt  = scaled_r[SAMPLE_W] ? OUT_MAX : scaled_r[SAMPLE_W-1:0];
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // window, ring index and output flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SAMPLES; i++) begin
        window_r[i] <= '0;
      end
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      window_r    <= window_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    sort_r     <= sort_nxt;
    acc_r      <= acc_nxt;
    mean_r     <= mean_nxt;
    scaled_r   <= scaled_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_chan.ready           = ctrl.in_ready;
  assign out_chan.valid          = out_valid_r;
  assign out_chan.smoothed_value = out_data_r;

endmodule

// ===== design/trimmed_mean_sample_smoother_unit.sv =====
// Trimmed-mean smoother for 12-bit converter samples. Each item is written into a ring
// window of SAMPLES entries (zero after reset, the first item lands in slot 1), the window
// is sorted, the sorted entries from max(TRIM_LOW,1) up to but not including
// min(TRIM_HIGH,SAMPLES-1) are averaged with truncation, and the mean is rescaled from
// 50..4000 onto 0..4095 and clamped. A small microcoded sequencer steps one shared
// datapath: an odd-even transposition sort, a summing pass up to the last sorted entry
// in range, then a step each for the mean and the rescale, both done by multiplying with
// a constant reciprocal. A new item is therefore accepted only once the previous one has
// passed through every step of the program. The result sits in an output register, so a
// new item is accepted while the previous result still waits to be taken; the emit step
// only holds if that earlier result is still waiting when the next one is ready.
module trimmed_mean_sample_smoother_unit #(
  parameter int SAMPLES   = 8,
  parameter int TRIM_LOW  = 2,
  parameter int TRIM_HIGH = 6
) (
  input  logic       clk,
  input  logic       rst_n,
  tmss_in_if.sink    in_chan,
  tmss_out_if.source out_chan
);
  import tmss_pkg::*;

  localparam int LO_IDX = (TRIM_LOW > 1) ? TRIM_LOW : 1;
  localparam int HI_IDX = (TRIM_HIGH < SAMPLES - 1) ? TRIM_HIGH : SAMPLES - 1;
  localparam int COUNT  = (HI_IDX > LO_IDX) ? HI_IDX - LO_IDX : 0;
  localparam int CW     = ($clog2(SAMPLES) > CNT_W) ? $clog2(SAMPLES) : CNT_W;

  ctrl_t         ctrl;
  stat_t         stat;
  logic [CW-1:0] cnt;

  // program sequencer
  tmss_seq #(
    .CW        (CW),
    .SORT_LAST (SAMPLES - 1),
    .SUM_LAST  (HI_IDX - 1)
  ) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl),
    .cnt   (cnt)
  );

  // window, sorter, accumulator and reciprocal multipliers
  tmss_datapath #(
    .SAMPLES (SAMPLES),
    .CW      (CW),
    .LO_IDX  (LO_IDX),
    .HI_IDX  (HI_IDX),
    .COUNT   (COUNT)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .ctrl     (ctrl),
    .cnt      (cnt),
    .stat     (stat)
  );

endmodule

// ===== bench/tb_trimmed_mean_sample_smoother_unit.sv =====
`timescale 1ns / 100ps

module tb_trimmed_mean_sample_smoother_unit;
  import tmss_pkg::*;

  localparam int SAMPLES      = 8;
  localparam int TRIM_LOW     = 2;
  localparam int TRIM_HIGH    = 6;
  localparam int RANDOM_ITEMS = 1950;
  localparam int DRAIN_CYCLES = 150;
  localparam int SUM_FIRST    = (TRIM_LOW > 1) ? TRIM_LOW : 1;
  localparam int SUM_LAST     = (TRIM_HIGH < SAMPLES - 1) ? TRIM_HIGH : SAMPLES - 1;
  localparam int IN_TOP       = 4000;

  logic clk;
  logic rst_n;

  tmss_in_if  in_chan ();
  tmss_out_if out_chan ();

  trimmed_mean_sample_smoother_unit #(
    .SAMPLES   (SAMPLES),
    .TRIM_LOW  (TRIM_LOW),
    .TRIM_HIGH (TRIM_HIGH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // shadow of the sample window and ring index
  logic [SAMPLE_W-1:0] window_ring [SAMPLES];
  int unsigned         ring_slot;

  logic [SAMPLE_W-1:0] sample_queue [$];
  logic [SAMPLE_W-1:0] smoothed_expected [$];

  int          total_items;
  int          items_sent;
  int          results_seen;
  int          mismatches;
  int          clamp_lo_seen;
  int          clamp_hi_seen;
  int unsigned send_idle_pct;
  int unsigned take_idle_pct;

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // write one sample into the ring and work out the smoothed value it yields
  function automatic logic [SAMPLE_W-1:0] smooth_sample(input logic [SAMPLE_W-1:0] s);
    int sorted [SAMPLES];
    int held;
    int j;
    int total;
    int count;
    int mean;
    int scaled;
    ring_slot = (ring_slot + 1) % SAMPLES;
    window_ring[ring_slot] = s;
    for (int i = 0; i < SAMPLES; i++) sorted[i] = int'(window_ring[i]);
    // insertion sort, ascending
    for (int i = 1; i < SAMPLES; i++) begin
      held = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > held) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = held;
    end
    total = 0;
    count = 0;
    for (int i = SUM_FIRST; i < SUM_LAST; i++) begin
      total += sorted[i];
      count++;
    end
    mean = (count != 0) ? total / count : 0;
    // rescale, truncating toward zero, then clamp
    scaled = ((mean - int'(IN_LOW)) * int'(OUT_MAX)) / int'(SCALE_DEN);
    if (scaled < 0) scaled = 0;
    else if (scaled > int'(OUT_MAX)) scaled = int'(OUT_MAX);
    return scaled[SAMPLE_W-1:0];
  endfunction

  // sample driver
  always @(posedge clk) begin : sample_driver
    logic hold;
    logic launch;
    if (!rst_n) begin
      in_chan.valid  <= 1'b0;
      in_chan.sample <= '0;
    end else begin
      hold = in_chan.valid && !in_chan.ready;
      if (in_chan.valid && in_chan.ready) begin
        smoothed_expected.push_back(smooth_sample(in_chan.sample));
        void'(sample_queue.pop_front());
        items_sent++;
      end
      if (!hold) begin
        launch = (sample_queue.size() != 0) && ($urandom_range(99) >= send_idle_pct);
        in_chan.valid <= launch;
        if (launch) in_chan.sample <= sample_queue[0];
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : result_monitor
    logic [SAMPLE_W-1:0] want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        results_seen++;
        if (smoothed_expected.size() == 0) begin
          $error("smoothed_value: no item pending, expected none, got %0d",
                 out_chan.smoothed_value);
          mismatches++;
        end else begin
          want = smoothed_expected.pop_front();
          if (out_chan.smoothed_value !== want) begin
            $error("smoothed_value: expected %0d, got %0d", want, out_chan.smoothed_value);
            mismatches++;
          end
          if (want == '0) clamp_lo_seen++;
          if (want == OUT_MAX) clamp_hi_seen++;
        end
      end
      out_chan.ready <= ($urandom_range(99) >= take_idle_pct);
    end
  end

  // stimulus, idling phases and end of run
  initial begin : stimulus
    int kind;
    int level;
    int spread;
    int burst;
    int v;
    in_chan.valid  = 1'b0;
    in_chan.sample = '0;
    out_chan.ready = 1'b0;
    rst_n          = 1'b0;
    ring_slot      = 0;
    foreach (window_ring[i]) window_ring[i] = '0;
    items_sent     = 0;
    results_seen   = 0;
    mismatches     = 0;
    clamp_lo_seen  = 0;
    clamp_hi_seen  = 0;
    send_idle_pct  = 9;
    take_idle_pct  = 49;

    // directed: window still mostly zero, top of range, rescale edges, bit patterns
    sample_queue.push_back(12'd0);
    repeat (6) sample_queue.push_back(12'hFFF);
    repeat (4) sample_queue.push_back(12'd4000);
    repeat (6) sample_queue.push_back(12'd50);
    sample_queue.push_back(12'd49);
    sample_queue.push_back(12'd51);
    sample_queue.push_back(12'hAAA);
    sample_queue.push_back(12'h555);
    sample_queue.push_back(12'h800);
    sample_queue.push_back(12'h7FF);
    sample_queue.push_back(12'd1);
    sample_queue.push_back(12'd4001);

    // random: noisy steady levels, runs near the rescale edges, raw full-range values
    while (sample_queue.size() < RANDOM_ITEMS + 24) begin
      kind = $urandom_range(9);
      if (kind <= 4) begin
        level  = $urandom_range(4095);
        spread = $urandom_range(64);
        burst  = $urandom_range(16, 4);
      end else if (kind <= 6) begin
        level  = ($urandom_range(1) == 0) ? int'(IN_LOW) : IN_TOP;
        spread = $urandom_range(20);
        burst  = $urandom_range(12, 6);
      end else begin
        level  = -1;
        spread = 0;
        burst  = $urandom_range(8, 1);
      end
      repeat (burst) begin
        if (level < 0) v = $urandom_range(4095);
        else v = level + $urandom_range(2 * spread) - spread;
        if (v < 0) v = 0;
        else if (v > 4095) v = 4095;
        sample_queue.push_back(v[SAMPLE_W-1:0]);
      end
    end
    total_items = sample_queue.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    wait (items_sent >= total_items / 3);
    send_idle_pct = 49;
    take_idle_pct = 9;
    wait (items_sent >= (2 * total_items) / 3);
    send_idle_pct = 0;
    take_idle_pct = 0;
    wait (items_sent == total_items && smoothed_expected.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d samples smoothed, %0d results checked, %0d mismatches",
             items_sent, results_seen, mismatches);
    $display("results clamped to zero: %0d, clamped to full scale: %0d",
             clamp_lo_seen, clamp_hi_seen);
    if (mismatches == 0 && smoothed_expected.size() == 0) begin
      $display("tb_trimmed_mean_sample_smoother_unit OK");
    end else begin
      $display("tb_trimmed_mean_sample_smoother_unit NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8_000_000;
    $display("tb_trimmed_mean_sample_smoother_unit NOT OK");
    $finish;
  end

endmodule
